// ===== hdl/rtksum_pkg.sv =====
// ----------------------------------------------------------------------------
// rtksum_pkg: shared types and constants of the running top-k sum core
// Field widths, register indexes, chain operation codes and the link record
// passed between neighboring cells of the sorted chains.
// ----------------------------------------------------------------------------
`default_nettype none

package rtksum_pkg;

    localparam int unsigned VALUE_W          = 32;
    localparam int unsigned SUM_W            = 42;
    localparam int unsigned COUNT_W          = 11;
    localparam int unsigned KEEP_SIZE_W      = 11;
    localparam int unsigned MAX_KEEP_DEFAULT = 1024;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    typedef enum logic
    {
        REG_KEEP_SIZE     = 1'b0,
        REG_KEEP_SMALLEST = 1'b1
    } reg_index_t;

    typedef enum logic [2:0]
    {
        OP_HOLD      = 3'd0,
        OP_GROW      = 3'd1,
        OP_DROP_HEAD = 3'd2,
        OP_DROP_TAIL = 3'd3,
        OP_RESTART   = 3'd4
    } chain_op_t;

    typedef struct packed
    {
        logic                      valid;
        logic                      ahead;
        logic signed [VALUE_W-1:0] value;
    } cell_link_t;

endpackage

`default_nettype wire

// ===== hdl/rtksum_cfg.sv =====
// ----------------------------------------------------------------------------
// rtksum_cfg: configuration registers
// APB-style register file holding the keep size and the keep-smallest mode.
// ----------------------------------------------------------------------------
`default_nettype none

module rtksum_cfg
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [rtksum_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [rtksum_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [rtksum_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                      pready,
    output logic      [rtksum_pkg::KEEP_SIZE_W-1:0]   keep_size,
    output logic                                      keep_smallest
);
    import rtksum_pkg::*;

    logic [KEEP_SIZE_W-1:0] keep_size_reg;
    logic [KEEP_SIZE_W-1:0] keep_size_next;
    logic                   keep_smallest_reg;
    logic                   keep_smallest_next;
    logic                   write_en;
    reg_index_t             index;

    assign pready   = 1'b1;
    assign write_en = psel && penable && pwrite && pready;
    assign index    = reg_index_t'(paddr[2]);

    always_comb
    begin
        keep_size_next     = keep_size_reg;
        keep_smallest_next = keep_smallest_reg;
        if (write_en)
        begin
            case (index)
                REG_KEEP_SIZE:     keep_size_next     = pwdata[KEEP_SIZE_W-1:0];
                REG_KEEP_SMALLEST: keep_smallest_next = pwdata[0];
                default:           keep_size_next     = keep_size_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_KEEP_SIZE:     prdata = APB_DATA_W'(keep_size_reg);
            REG_KEEP_SMALLEST: prdata = APB_DATA_W'(keep_smallest_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_size_reg     <= KEEP_SIZE_W'(1);
            keep_smallest_reg <= 1'b0;
        end
        else
        begin
            keep_size_reg     <= keep_size_next;
            keep_smallest_reg <= keep_smallest_next;
        end
    end

    assign keep_size     = keep_size_reg;
    assign keep_smallest = keep_smallest_reg;

endmodule

`default_nettype wire

// ===== hdl/rtksum_cell.sv =====
// ----------------------------------------------------------------------------
// rtksum_cell: one cell of a sorted chain
// Holds one value and its valid bit; compares against the broadcast sample
// and shifts, inserts or holds according to the chain operation.
// ----------------------------------------------------------------------------
`default_nettype none

module rtksum_cell
#(
    parameter bit DESCENDING = 1'b0,
    parameter bit IS_HEAD    = 1'b0
)
(
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire rtksum_pkg::chain_op_t                     op,
    input  wire logic signed [rtksum_pkg::VALUE_W-1:0]     sample,
    input  wire rtksum_pkg::cell_link_t                    left,
    input  wire rtksum_pkg::cell_link_t                    right,
    output rtksum_pkg::cell_link_t                         link
);
    import rtksum_pkg::*;

    logic                      valid_reg;
    logic                      valid_next;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      ahead;
    logic                      load;
    logic signed [VALUE_W-1:0] insert_value;

    assign ahead = valid_reg && (DESCENDING ? (value_reg > sample) : (value_reg < sample));

    // shift right on insert
    assign insert_value = ahead ? value_reg : (left.ahead ? sample : left.value);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        load       = 1'b0;
        case (op)
            OP_HOLD:
            begin
                load = 1'b0;
            end
            OP_GROW:
            begin
                valid_next = valid_reg || left.valid;
                value_next = insert_value;
                load       = valid_next;
            end
            OP_DROP_TAIL:
            begin
                value_next = insert_value;
                load       = valid_reg;
            end
            OP_DROP_HEAD:
            begin
                value_next = right.ahead ? right.value : (ahead ? sample : value_reg);
                load       = valid_reg;
            end
            OP_RESTART:
            begin
                valid_next = IS_HEAD;
                value_next = sample;
                load       = IS_HEAD;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= value_next;
        end
    end

    assign link.valid = valid_reg;
    assign link.ahead = ahead;
    assign link.value = value_reg;

endmodule

`default_nettype wire

// ===== hdl/rtksum_chain.sv =====
// ----------------------------------------------------------------------------
// rtksum_chain: sorted chain of cells
// A row of cells kept sorted in one direction; the head cell always holds the
// first value of the order (the smallest when ascending, largest when not).
// ----------------------------------------------------------------------------
`default_nettype none

module rtksum_chain
#(
    parameter int unsigned DEPTH      = rtksum_pkg::MAX_KEEP_DEFAULT,
    parameter bit          DESCENDING = 1'b0
)
(
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire rtksum_pkg::chain_op_t                     op,
    input  wire logic signed [rtksum_pkg::VALUE_W-1:0]     sample,
    output logic signed      [rtksum_pkg::VALUE_W-1:0]     head_value
);
    import rtksum_pkg::*;

    cell_link_t links      [DEPTH];
    cell_link_t left_links [DEPTH];
    cell_link_t right_links[DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                assign left_links[i] = '{valid: 1'b1, ahead: 1'b1, value: '0};
            end
            else
            begin : g_body
                assign left_links[i] = links[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign right_links[i] = '{valid: 1'b0, ahead: 1'b0, value: '0};
            end
            else
            begin : g_inner
                assign right_links[i] = links[i+1];
            end

            rtksum_cell
            #(
                .DESCENDING (DESCENDING),
                .IS_HEAD    (i == 0)
            )
            u_cell
            (
                .clk    (clk),
                .rst_n  (rst_n),
                .op     (op),
                .sample (sample),
                .left   (left_links[i]),
                .right  (right_links[i]),
                .link   (links[i])
            );
        end
    endgenerate

    assign head_value = links[0].value;

endmodule

`default_nettype wire

// ===== hdl/running_top_k_sum_core.sv =====
// ----------------------------------------------------------------------------
// running_top_k_sum_core: running sum of the k best values of a stream
// Requests carry a signed value and a restart flag. Each request yields one
// response with the sum and count of the kept values after that request.
// Configuration (keep_size, keep_smallest) is written over the APB port at
// byte addresses 0 and 4 while no request is in flight.
// Two chains of MAX_KEEP cells, one ascending and one descending, hold the
// kept multiset; their head cells give the smallest and largest kept value,
// and every cell compares and shifts in the same cycle.
// Path: the request register loads at acceptance, then the chain update
// writes the response register, which raises rsp_valid.
// Throughput: one request per cycle while the response is not stalled.
// Reset clears the kept set, the count and the sum, and sets keep_size to 1
// and keep_smallest to 0; no clearing pass is needed.
// While rsp_stall is high the response register holds, and req_stall rises
// once a request is waiting behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module running_top_k_sum_core
#(
    parameter int unsigned MAX_KEEP = rtksum_pkg::MAX_KEEP_DEFAULT
)
(
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     psel,
    input  wire logic                                     penable,
    input  wire logic                                     pwrite,
    input  wire logic        [rtksum_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic        [rtksum_pkg::APB_DATA_W-1:0] pwdata,
    output logic             [rtksum_pkg::APB_DATA_W-1:0] prdata,
    output logic                                          pready,
    input  wire logic                                     req_valid,
    output logic                                          req_stall,
    input  wire logic signed [rtksum_pkg::VALUE_W-1:0]    value,
    input  wire logic                                     restart,
    output logic                                          rsp_valid,
    input  wire logic                                     rsp_stall,
    output logic signed      [rtksum_pkg::SUM_W-1:0]      kept_sum,
    output logic             [rtksum_pkg::COUNT_W-1:0]    kept_count
);
    import rtksum_pkg::*;

    localparam int unsigned CW = $clog2(MAX_KEEP + 1);
    localparam int unsigned KW = (CW > KEEP_SIZE_W) ? CW : KEEP_SIZE_W;

    logic [KEEP_SIZE_W-1:0] keep_size;
    logic                   keep_smallest;

    logic                      req_valid_reg;
    logic                      req_valid_next;
    logic signed [VALUE_W-1:0] value_reg;
    logic                      restart_reg;
    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    logic signed [SUM_W-1:0]   kept_sum_reg;
    logic [COUNT_W-1:0]        kept_count_reg;

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   sum_next;

    logic                      advance;
    logic                      fire;
    logic                      req_take;
    logic [KW-1:0]             keep_wide;
    logic [KW-1:0]             keep_limit;
    logic [KW-1:0]             count_wide;
    logic [KW-1:0]             count_next_wide;
    logic signed [VALUE_W-1:0] min_value;
    logic signed [VALUE_W-1:0] max_value;
    chain_op_t                 asc_op;
    chain_op_t                 desc_op;

    rtksum_cfg u_cfg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .keep_size     (keep_size),
        .keep_smallest (keep_smallest)
    );

    rtksum_chain
    #(
        .DEPTH      (MAX_KEEP),
        .DESCENDING (1'b0)
    )
    u_asc
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (asc_op),
        .sample     (value_reg),
        .head_value (min_value)
    );

    rtksum_chain
    #(
        .DEPTH      (MAX_KEEP),
        .DESCENDING (1'b1)
    )
    u_desc
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (desc_op),
        .sample     (value_reg),
        .head_value (max_value)
    );

    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign fire      = req_valid_reg && advance;
    assign req_stall = req_valid_reg && !advance;
    assign req_take  = req_valid && !req_stall;

    assign req_valid_next = req_take ? 1'b1 : (fire ? 1'b0 : req_valid_reg);
    assign rsp_valid_next = fire ? 1'b1 : (rsp_stall ? rsp_valid_reg : 1'b0);

    assign keep_wide  = KW'(keep_size);
    assign count_wide = KW'(count_reg);

    always_comb
    begin
        if (keep_wide == '0)
        begin
            keep_limit = KW'(1);
        end
        else if (keep_wide > KW'(MAX_KEEP))
        begin
            keep_limit = KW'(MAX_KEEP);
        end
        else
        begin
            keep_limit = keep_wide;
        end
    end

    always_comb
    begin
        asc_op     = OP_HOLD;
        desc_op    = OP_HOLD;
        count_next = count_reg;
        sum_next   = sum_reg;
        if (fire)
        begin
            if (restart_reg)
            begin
                asc_op     = OP_RESTART;
                desc_op    = OP_RESTART;
                count_next = CW'(1);
                sum_next   = SUM_W'(value_reg);
            end
            else if (count_wide < keep_limit)
            begin
                asc_op     = OP_GROW;
                desc_op    = OP_GROW;
                count_next = count_reg + CW'(1);
                sum_next   = sum_reg + SUM_W'(value_reg);
            end
            else if (!keep_smallest && (value_reg > min_value))
            begin
                // replace the smallest kept value
                asc_op   = OP_DROP_HEAD;
                desc_op  = OP_DROP_TAIL;
                sum_next = sum_reg + SUM_W'(value_reg) - SUM_W'(min_value);
            end
            else if (keep_smallest && (value_reg < max_value))
            begin
                // replace the largest kept value
                asc_op   = OP_DROP_TAIL;
                desc_op  = OP_DROP_HEAD;
                sum_next = sum_reg + SUM_W'(value_reg) - SUM_W'(max_value);
            end
        end
    end

    assign count_next_wide = KW'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
            sum_reg       <= '0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            value_reg   <= value;
            restart_reg <= restart;
        end
        if (fire)
        begin
            kept_sum_reg   <= sum_next;
            kept_count_reg <= count_next_wide[COUNT_W-1:0];
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign kept_sum   = kept_sum_reg;
    assign kept_count = kept_count_reg;

endmodule

`default_nettype wire
